// File: hdl/mhr_pkg.sv
// ----------------------------------------------------------------------------
// mhr_pkg
// Shared widths, codes and types of the modular homography root map.
// ----------------------------------------------------------------------------
package mhr_pkg;

  localparam int ROOT_BITS = 32;
  localparam int FIELD_W   = 32;
  localparam int COEF_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int SGN_W     = FIELD_W + 2;
  localparam int PROD_W    = 2 * FIELD_W;
  localparam int DCNT_W    = 7;

  localparam logic [FIELD_W-1:0] ROOT_MASK = FIELD_W'((65'd1 << ROOT_BITS) - 65'd1);

  typedef enum logic [1:0] {
    REG_COEF_A = 2'd0,
    REG_COEF_B = 2'd1,
    REG_COEF_C = 2'd2,
    REG_COEF_D = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_TRIVIAL,
    OP_MUL_MAG,
    OP_MUL_RC,
    OP_MUL_RA,
    OP_MUL_NI,
    OP_MUL_QS,
    OP_DIV_MOD,
    OP_DIV_EUC,
    OP_WR_RES,
    OP_DEN_FIN,
    OP_DEN_INF,
    OP_EUC_INIT,
    OP_EUC_UPD,
    OP_INV_FIX,
    OP_SET_INF,
    OP_NUM_FIN,
    OP_NUM_INF,
    OP_WR_OUT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_RMUL,
    S_RDIV,
    S_RWAIT,
    S_DEN,
    S_DDIV,
    S_DWAIT,
    S_EINIT,
    S_ETEST,
    S_EWAIT,
    S_EUPD,
    S_EEND,
    S_NUM,
    S_NDIV,
    S_NWAIT,
    S_FMUL,
    S_FDIV,
    S_FWAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                  op;
    logic [CFG_IDX_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic deg;
    logic infin;
    logic div_done;
    logic rr_zero;
    logic or_one;
  } status_t;

endpackage

// File: hdl/mhr_in_if.sv
// ----------------------------------------------------------------------------
// mhr_in_if
// Input item channel: modulus and root.
// ----------------------------------------------------------------------------
interface mhr_in_if;
  logic                          valid;
  logic                          ready;
  logic [mhr_pkg::FIELD_W-1:0]   modulus;
  logic [mhr_pkg::FIELD_W-1:0]   root_in;

  modport source (output valid, output modulus, output root_in, input ready);
  modport sink   (input valid, input modulus, input root_in, output ready);
endinterface

// File: hdl/mhr_out_if.sv
// ----------------------------------------------------------------------------
// mhr_out_if
// Result item channel: image root and flags.
// ----------------------------------------------------------------------------
interface mhr_out_if;
  logic                          valid;
  logic                          ready;
  logic [mhr_pkg::FIELD_W-1:0]   root_out;
  logic                          at_infinity;
  logic                          bad_root;

  modport source (output valid, output root_out, output at_infinity, output bad_root,
                  input ready);
  modport sink   (input valid, input root_out, input at_infinity, input bad_root,
                  output ready);
endinterface

// File: hdl/mhr_ctrl.sv
// ----------------------------------------------------------------------------
// mhr_ctrl
// Sequencer: steps the datapath through residues, denominator, inverse and
// final product, one item at a time.
// ----------------------------------------------------------------------------
module mhr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mhr_pkg::status_t status,
  output mhr_pkg::cmd_t    cmd
);

  mhr_pkg::state_t                 state, state_next;
  logic [mhr_pkg::CFG_IDX_W-1:0]   k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhr_pkg::S_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    unique case (state)
      mhr_pkg::S_IDLE:  if (in_valid) state_next = mhr_pkg::S_CHECK;
      mhr_pkg::S_CHECK: begin
        k_next = '0;
        if (status.bad || status.deg) state_next = mhr_pkg::S_DONE;
        else state_next = mhr_pkg::S_RMUL;
      end
      mhr_pkg::S_RMUL:  state_next = mhr_pkg::S_RDIV;
      mhr_pkg::S_RDIV:  state_next = mhr_pkg::S_RWAIT;
      mhr_pkg::S_RWAIT: if (status.div_done) begin
        k_next = k + 1'b1;
        if (k == mhr_pkg::CFG_IDX_W'(mhr_pkg::REG_COEF_D)) state_next = mhr_pkg::S_DEN;
        else state_next = mhr_pkg::S_RMUL;
      end
      mhr_pkg::S_DEN: begin
        if (status.infin) state_next = mhr_pkg::S_EINIT;
        else state_next = mhr_pkg::S_DDIV;
      end
      mhr_pkg::S_DDIV:  state_next = mhr_pkg::S_DWAIT;
      mhr_pkg::S_DWAIT: if (status.div_done) state_next = mhr_pkg::S_EINIT;
      mhr_pkg::S_EINIT: state_next = mhr_pkg::S_ETEST;
      mhr_pkg::S_ETEST: begin
        if (status.rr_zero) state_next = mhr_pkg::S_EEND;
        else state_next = mhr_pkg::S_EWAIT;
      end
      mhr_pkg::S_EWAIT: if (status.div_done) state_next = mhr_pkg::S_EUPD;
      mhr_pkg::S_EUPD:  state_next = mhr_pkg::S_ETEST;
      mhr_pkg::S_EEND: begin
        if (status.or_one) state_next = mhr_pkg::S_NUM;
        else state_next = mhr_pkg::S_DONE;
      end
      mhr_pkg::S_NUM: begin
        if (status.infin) state_next = mhr_pkg::S_FMUL;
        else state_next = mhr_pkg::S_NDIV;
      end
      mhr_pkg::S_NDIV:  state_next = mhr_pkg::S_NWAIT;
      mhr_pkg::S_NWAIT: if (status.div_done) state_next = mhr_pkg::S_FMUL;
      mhr_pkg::S_FMUL:  state_next = mhr_pkg::S_FDIV;
      mhr_pkg::S_FDIV:  state_next = mhr_pkg::S_FWAIT;
      mhr_pkg::S_FWAIT: if (status.div_done) state_next = mhr_pkg::S_DONE;
      mhr_pkg::S_DONE:  if (out_ready) state_next = mhr_pkg::S_IDLE;
      default:          state_next = mhr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op    = mhr_pkg::OP_NONE;
    cmd.k     = k;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      mhr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = mhr_pkg::OP_LOAD;
      end
      mhr_pkg::S_CHECK: if (status.bad || status.deg) cmd.op = mhr_pkg::OP_TRIVIAL;
      mhr_pkg::S_RMUL:  cmd.op = mhr_pkg::OP_MUL_MAG;
      mhr_pkg::S_RDIV:  cmd.op = mhr_pkg::OP_DIV_MOD;
      mhr_pkg::S_RWAIT: if (status.div_done) cmd.op = mhr_pkg::OP_WR_RES;
      mhr_pkg::S_DEN: begin
        if (status.infin) cmd.op = mhr_pkg::OP_DEN_INF;
        else cmd.op = mhr_pkg::OP_MUL_RC;
      end
      mhr_pkg::S_DDIV:  cmd.op = mhr_pkg::OP_DIV_MOD;
      mhr_pkg::S_DWAIT: if (status.div_done) cmd.op = mhr_pkg::OP_DEN_FIN;
      mhr_pkg::S_EINIT: cmd.op = mhr_pkg::OP_EUC_INIT;
      mhr_pkg::S_ETEST: if (!status.rr_zero) cmd.op = mhr_pkg::OP_DIV_EUC;
      mhr_pkg::S_EWAIT: if (status.div_done) cmd.op = mhr_pkg::OP_MUL_QS;
      mhr_pkg::S_EUPD:  cmd.op = mhr_pkg::OP_EUC_UPD;
      mhr_pkg::S_EEND: begin
        if (status.or_one) cmd.op = mhr_pkg::OP_INV_FIX;
        else cmd.op = mhr_pkg::OP_SET_INF;
      end
      mhr_pkg::S_NUM: begin
        if (status.infin) cmd.op = mhr_pkg::OP_NUM_INF;
        else cmd.op = mhr_pkg::OP_MUL_RA;
      end
      mhr_pkg::S_NDIV:  cmd.op = mhr_pkg::OP_DIV_MOD;
      mhr_pkg::S_NWAIT: if (status.div_done) cmd.op = mhr_pkg::OP_NUM_FIN;
      mhr_pkg::S_FMUL:  cmd.op = mhr_pkg::OP_MUL_NI;
      mhr_pkg::S_FDIV:  cmd.op = mhr_pkg::OP_DIV_MOD;
      mhr_pkg::S_FWAIT: if (status.div_done) cmd.op = mhr_pkg::OP_WR_OUT;
      mhr_pkg::S_DONE:  out_valid = 1'b1;
      default:          cmd.op = mhr_pkg::OP_NONE;
    endcase
  end

endmodule

// File: hdl/mhr_dp.sv
// ----------------------------------------------------------------------------
// mhr_dp
// Datapath: coefficient registers, one multiplier, a restoring divider and
// the extended Euclid registers.
// ----------------------------------------------------------------------------
module mhr_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mhr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mhr_pkg::COEF_W-1:0]         cfg_data,
  input  logic [mhr_pkg::FIELD_W-1:0]        modulus,
  input  logic [mhr_pkg::FIELD_W-1:0]        root_in,
  input  mhr_pkg::cmd_t                      cmd,
  output mhr_pkg::status_t                   status,
  output logic [mhr_pkg::FIELD_W-1:0]        root_out,
  output logic                               at_infinity,
  output logic                               bad_root
);

  localparam int W  = mhr_pkg::FIELD_W;
  localparam int SW = mhr_pkg::SGN_W;

  logic signed [mhr_pkg::COEF_W-1:0] coef [4];

  logic [W-1:0]  p, r, ra, rb, rc, rd, den, num, inv;
  logic          bad, deg, infin;
  logic [W-1:0]  oldr, rr;
  logic signed [SW-1:0] os, s;
  logic [mhr_pkg::PROD_W-1:0] prod;

  // divider
  logic [mhr_pkg::PROD_W-1:0] dn;
  logic [W-1:0]               rm, dv;
  logic [mhr_pkg::DCNT_W-1:0] dcnt;
  logic                       dbusy, ddone;
  logic [W:0]                 dsh;
  logic                       dge;

  logic signed [mhr_pkg::COEF_W-1:0] ck;
  logic [mhr_pkg::COEF_W-1:0]        mag;
  logic signed [SW-1:0]              opx, opy;
  logic signed [2*SW-1:0]            mprod;
  logic [W-1:0]                      neg_val;
  logic [W-1:0]                      addx;
  logic [W:0]                        asum;
  logic [W-1:0]                      amod;
  logic signed [SW-1:0]              ifix;
  logic [W-1:0]                      inv_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[mhr_pkg::REG_COEF_A] <= 8'sd1;
      coef[mhr_pkg::REG_COEF_B] <= 8'sd0;
      coef[mhr_pkg::REG_COEF_C] <= 8'sd0;
      coef[mhr_pkg::REG_COEF_D] <= 8'sd1;
    end else if (cfg_we) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  assign ck  = coef[cmd.k];
  assign mag = ck[mhr_pkg::COEF_W-1] ? mhr_pkg::COEF_W'(-ck) : ck;

  always_comb begin
    opx = '0;
    opy = '0;
    unique case (cmd.op)
      mhr_pkg::OP_MUL_MAG: begin
        opx = SW'({1'b0, mag});
        opy = SW'(1);
      end
      mhr_pkg::OP_MUL_RC: begin
        opx = SW'({1'b0, r});
        opy = SW'({1'b0, rc});
      end
      mhr_pkg::OP_MUL_RA: begin
        opx = SW'({1'b0, r});
        opy = SW'({1'b0, ra});
      end
      mhr_pkg::OP_MUL_NI: begin
        opx = SW'({1'b0, num});
        opy = SW'({1'b0, inv});
      end
      mhr_pkg::OP_MUL_QS: begin
        opx = SW'({1'b0, dn[W-1:0]});
        opy = s;
      end
      default: begin
        opx = '0;
        opy = '0;
      end
    endcase
  end

  assign mprod = opx * opy;

  // modular add of the last remainder and a stored residue
  always_comb begin
    addx = (cmd.op == mhr_pkg::OP_NUM_FIN) ? rb : rd;
    asum = {1'b0, rm} + {1'b0, addx};
    amod = (asum >= {1'b0, p}) ? W'(asum - {1'b0, p}) : asum[W-1:0];
  end

  assign neg_val = (ck[mhr_pkg::COEF_W-1] && (rm != '0)) ? (p - rm) : rm;
  assign ifix    = os[SW-1] ? (SW'({1'b0, p}) + os) : os;
  assign inv_val = (ifix >= SW'({1'b0, p})) ? W'(ifix - SW'({1'b0, p})) : ifix[W-1:0];

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      mhr_pkg::OP_LOAD: begin
        p     <= modulus & mhr_pkg::ROOT_MASK;
        r     <= root_in & mhr_pkg::ROOT_MASK;
        bad   <= (root_in & mhr_pkg::ROOT_MASK) > (modulus & mhr_pkg::ROOT_MASK);
        deg   <= (modulus & mhr_pkg::ROOT_MASK) < W'(2);
        infin <= (root_in & mhr_pkg::ROOT_MASK) == (modulus & mhr_pkg::ROOT_MASK);
      end
      mhr_pkg::OP_TRIVIAL: begin
        root_out    <= '0;
        at_infinity <= 1'b0;
        bad_root    <= bad;
      end
      mhr_pkg::OP_MUL_MAG, mhr_pkg::OP_MUL_RC, mhr_pkg::OP_MUL_RA,
      mhr_pkg::OP_MUL_NI, mhr_pkg::OP_MUL_QS: prod <= mprod[mhr_pkg::PROD_W-1:0];
      mhr_pkg::OP_WR_RES: begin
        unique case (cmd.k)
          mhr_pkg::REG_COEF_A: ra <= neg_val;
          mhr_pkg::REG_COEF_B: rb <= neg_val;
          mhr_pkg::REG_COEF_C: rc <= neg_val;
          mhr_pkg::REG_COEF_D: rd <= neg_val;
          default:             rd <= neg_val;
        endcase
      end
      mhr_pkg::OP_DEN_FIN: den <= amod;
      mhr_pkg::OP_DEN_INF: den <= rc;
      mhr_pkg::OP_EUC_INIT: begin
        oldr <= den;
        rr   <= p;
        os   <= SW'(1);
        s    <= '0;
      end
      mhr_pkg::OP_EUC_UPD: begin
        oldr <= rr;
        rr   <= rm;
        os   <= s;
        s    <= os - $signed(prod[SW-1:0]);
      end
      mhr_pkg::OP_INV_FIX: inv <= inv_val;
      mhr_pkg::OP_SET_INF: begin
        root_out    <= p;
        at_infinity <= 1'b1;
        bad_root    <= 1'b0;
      end
      mhr_pkg::OP_NUM_FIN: num <= amod;
      mhr_pkg::OP_NUM_INF: num <= ra;
      mhr_pkg::OP_WR_OUT: begin
        root_out    <= rm;
        at_infinity <= 1'b0;
        bad_root    <= 1'b0;
      end
      default: ;
    endcase
  end

  // restoring divider, one quotient bit a cycle
  assign dsh = {rm, dn[mhr_pkg::PROD_W-1]};
  assign dge = dsh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      ddone <= 1'b0;
      dcnt  <= '0;
    end else begin
      ddone <= 1'b0;
      if (cmd.op == mhr_pkg::OP_DIV_MOD) begin
        dbusy <= 1'b1;
        dcnt  <= mhr_pkg::DCNT_W'(mhr_pkg::PROD_W);
      end else if (cmd.op == mhr_pkg::OP_DIV_EUC) begin
        dbusy <= 1'b1;
        dcnt  <= mhr_pkg::DCNT_W'(W);
      end else if (dbusy) begin
        dcnt <= dcnt - 1'b1;
        if (dcnt == mhr_pkg::DCNT_W'(1)) begin
          dbusy <= 1'b0;
          ddone <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == mhr_pkg::OP_DIV_MOD) begin
      dn <= prod;
      dv <= p;
      rm <= '0;
    end else if (cmd.op == mhr_pkg::OP_DIV_EUC) begin
      dn <= {oldr, {W{1'b0}}};
      dv <= rr;
      rm <= '0;
    end else if (dbusy) begin
      rm <= dge ? W'(dsh - {1'b0, dv}) : dsh[W-1:0];
      dn <= {dn[mhr_pkg::PROD_W-2:0], dge};
    end
  end

  assign status.bad      = bad;
  assign status.deg      = deg;
  assign status.infin    = infin;
  assign status.div_done = ddone;
  assign status.rr_zero  = (rr == '0);
  assign status.or_one   = (oldr == W'(1));

endmodule

// File: hdl/modular_homography_root_map.sv
// Each modular reduction and each extended Euclid quotient runs on the one
//   restoring divider.
// Throughput: one item at a time; the next item is taken once the result
//   has been delivered.
// Reset: synchronous, active high; coefficients return to 1, 0, 0, 1.
// ----------------------------------------------------------------------------
// modular_homography_root_map
// Maps a root mod p through (A*r+B)/(C*r+D), infinity as root equal to p.
// ----------------------------------------------------------------------------
module modular_homography_root_map (
  input  logic                          clk,
  input  logic                          rst,
  mhr_in_if.sink                        in_item,
  mhr_out_if.source                     out_item,
  input  logic                          cfg_we,
  input  logic [mhr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mhr_pkg::COEF_W-1:0]    cfg_data
);

  mhr_pkg::cmd_t    cmd;
  mhr_pkg::status_t status;

  mhr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mhr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .modulus     (in_item.modulus),
    .root_in     (in_item.root_in),
    .cmd         (cmd),
    .status      (status),
    .root_out    (out_item.root_out),
    .at_infinity (out_item.at_infinity),
    .bad_root    (out_item.bad_root)
  );

endmodule

// File: hdl/mhr_checker.sv
// ----------------------------------------------------------------------------
// mhr_checker
// Port-level checks of the root map, bound to the top level.
// ----------------------------------------------------------------------------
module mhr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mhr_pkg::FIELD_W-1:0] root_out,
  input logic                        at_infinity,
  input logic                        bad_root
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(root_out) && $stable(bad_root))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while a result waits");

  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("result in the cycle after an item");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_root |-> root_out == '0 && !at_infinity)
    else $error("bad root with non-zero result");

endmodule

bind modular_homography_root_map mhr_checker u_mhr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_item.valid),
  .in_ready    (in_item.ready),
  .out_valid   (out_item.valid),
  .out_ready   (out_item.ready),
  .root_out    (out_item.root_out),
  .at_infinity (out_item.at_infinity),
  .bad_root    (out_item.bad_root)
);
